>>> design/chtab_pkg.sv
// Package for the chained hash table: sizes, pointer width, operation and
// status codes, and the request record passed from front to back.
// No dependencies.
`default_nettype none
package chtab_pkg;

	localparam int BUCKETS = 16;
	localparam int NODES   = 64;
	localparam int VAL_W   = 31;
	localparam int PTR_W   = $clog2(NODES + 1);
	localparam int ADDR_W  = $clog2(NODES);
	localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] value;
		logic [BKT_W-1:0] bkt;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} head_t;

	function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
		return p < NIL;
	endfunction

endpackage
`default_nettype wire

>>> design/chtab_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module chtab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> design/chtab_front.sv
// Front end of the chained hash table: accepts requests, works out the
// bucket and holds them in a two-entry queue for the back end.
// Depends on chtab_pkg.
`default_nettype none
module chtab_front import chtab_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       req_type,
	input  wire logic [VAL_W-1:0] value,
	input  wire logic             pop,
	output head_t                 head
);

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       take;
	req_t       incoming;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign take     = pop && (count_q != 2'd0);

	always_comb begin
		incoming.op    = op_t'(req_type);
		incoming.value = value;
		incoming.bkt   = BKT_W'(value % BUCKETS);
	end

	assign head.valid = (count_q != 2'd0);
	assign head.req   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/chtab_back.sv
// Back end of the chained hash table: bucket heads, node pool, free list,
// chain walker and the result register.
// Depends on chtab_pkg and chtab_ram.
`default_nettype none
module chtab_back import chtab_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire head_t  head,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic [1:0]  status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_INS,
		S_LOOK,
		S_FREE,
		S_RESP
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [VAL_W-1:0] val_q;
	logic [BKT_W-1:0] bkt_q;
	logic [PTR_W-1:0] bhead_q [BUCKETS];
	logic [PTR_W-1:0] free_head_q;
	logic [PTR_W-1:0] unused_q;
	logic [PTR_W-1:0] p_q;
	logic [PTR_W-1:0] prev_q;
	logic [PTR_W-1:0] steps_q;
	status_t          res_q;
	logic             out_valid_q;
	logic [1:0]       status_q;

	logic [PTR_W-1:0]  p_head;
	logic [PTR_W-1:0]  steps_nx;
	logic [ADDR_W-1:0] rd_addr;
	logic [VAL_W-1:0]  rd_value;
	logic [PTR_W-1:0]  rd_link;
	logic              val_we;
	logic              link_we;
	logic [ADDR_W-1:0] val_waddr;
	logic [ADDR_W-1:0] link_waddr;
	logic [PTR_W-1:0]  link_wdata;
	logic              match;
	logic              slot_free;

	assign p_head    = bhead_q[bkt_q];
	assign steps_nx  = steps_q + 1'b1;
	assign match     = (rd_value == val_q);
	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = (state_q == S_IDLE) && head.valid;
	assign out_valid = out_valid_q;
	assign status    = status_q;

	always_comb begin
		rd_addr    = free_head_q[ADDR_W-1:0];
		val_we     = 1'b0;
		link_we    = 1'b0;
		val_waddr  = unused_q[ADDR_W-1:0];
		link_waddr = unused_q[ADDR_W-1:0];
		link_wdata = p_head;
		unique case (state_q)
			S_DISP: begin
				if (op_q == OP_INSERT) begin
					if (!ptr_ok(free_head_q) && ptr_ok(unused_q)) begin
						val_we  = 1'b1;
						link_we = 1'b1;
					end
				end else begin
					rd_addr = p_head[ADDR_W-1:0];
				end
			end
			S_INS: begin
				val_we     = 1'b1;
				link_we    = 1'b1;
				val_waddr  = free_head_q[ADDR_W-1:0];
				link_waddr = free_head_q[ADDR_W-1:0];
			end
			S_LOOK: begin
				rd_addr = rd_link[ADDR_W-1:0];
				if (match && op_q == OP_DELETE && ptr_ok(prev_q)) begin
					link_we    = 1'b1;
					link_waddr = prev_q[ADDR_W-1:0];
					link_wdata = rd_link;
				end
			end
			S_FREE: begin
				link_we    = 1'b1;
				link_waddr = p_q[ADDR_W-1:0];
				link_wdata = free_head_q;
			end
			default: begin
				rd_addr = free_head_q[ADDR_W-1:0];
			end
		endcase
	end

	chtab_ram #(
		.WIDTH(VAL_W),
		.DEPTH(NODES)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(val_waddr),
		.wdata(val_q),
		.raddr(rd_addr),
		.rdata(rd_value)
	);

	chtab_ram #(
		.WIDTH(PTR_W),
		.DEPTH(NODES)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(rd_addr),
		.rdata(rd_link)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_INSERT;
			val_q       <= '0;
			bkt_q       <= '0;
			for (int i = 0; i < BUCKETS; i++) begin
				bhead_q[i] <= NIL;
			end
			free_head_q <= NIL;
			unused_q    <= '0;
			p_q         <= NIL;
			prev_q      <= NIL;
			steps_q     <= '0;
			res_q       <= ST_NOTFOUND;
			out_valid_q <= 1'b0;
			status_q    <= ST_NOTFOUND;
		end else begin
			if (state_q == S_RESP && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						op_q    <= head.req.op;
						val_q   <= head.req.value;
						bkt_q   <= head.req.bkt;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					prev_q  <= NIL;
					steps_q <= '0;
					p_q     <= p_head;
					case (op_q) inside
						OP_INSERT: begin
							if (ptr_ok(free_head_q)) begin
								state_q <= S_INS;
							end else if (ptr_ok(unused_q)) begin
								bhead_q[bkt_q] <= unused_q;
								unused_q       <= unused_q + 1'b1;
								res_q          <= ST_DONE;
								state_q        <= S_RESP;
							end else begin
								res_q   <= ST_FULL;
								state_q <= S_RESP;
							end
						end
						OP_DELETE, OP_SEARCH: begin
							if (ptr_ok(p_head)) begin
								state_q <= S_LOOK;
							end else begin
								res_q   <= ST_NOTFOUND;
								state_q <= S_RESP;
							end
						end
						default: begin
							res_q   <= ST_NOTFOUND;
							state_q <= S_RESP;
						end
					endcase
				end
				S_INS: begin
					bhead_q[bkt_q] <= free_head_q;
					free_head_q    <= rd_link;
					res_q          <= ST_DONE;
					state_q        <= S_RESP;
				end
				S_LOOK: begin
					if (match) begin
						res_q <= ST_DONE;
						if (op_q == OP_DELETE) begin
							if (!ptr_ok(prev_q)) begin
								bhead_q[bkt_q] <= rd_link;
							end
							state_q <= S_FREE;
						end else begin
							state_q <= S_RESP;
						end
					end else begin
						prev_q  <= p_q;
						p_q     <= rd_link;
						steps_q <= steps_nx;
						if (!ptr_ok(rd_link) || !(steps_nx < NIL)) begin
							res_q   <= ST_NOTFOUND;
							state_q <= S_RESP;
						end
					end
				end
				S_FREE: begin
					free_head_q <= p_q;
					state_q     <= S_RESP;
				end
				S_RESP: begin
					if (slot_free) begin
						status_q <= res_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/chained_hash_table.sv
// Top level of the chained hash table: front end, request queue, back end.
// Depends on chtab_pkg, chtab_front and chtab_back.
//
// A hash set of 31-bit values in BUCKETS chains built from a pool of NODES
// nodes. Each transfer on the request side gives exactly one status transfer,
// in order. The front end queues up to two requests while the back end works.
// An insert that takes its node from the free list passes through the extra
// state S_INS in the back end, and a delete that hits passes through S_FREE.
// Searches and deletes walk the chain one node per cycle through the single
// read port of the node value and link memories. No clearing pass follows
// reset.
`default_nettype none
module chained_hash_table import chtab_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       req_type,
	input  wire logic [VAL_W-1:0] value,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            status
);

	head_t head;
	logic  pop;

	chtab_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.value   (value),
		.pop     (pop),
		.head    (head)
	);

	chtab_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status)
	);

endmodule
`default_nettype wire

>>> design/chtab_checker.sv
// Port-level checker for the chained hash table, bound to the top level.
// Depends on chained_hash_table.
`default_nettype none
module chtab_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] status
);

	logic [2:0] pending_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + {2'b00, in_xfer} - {2'b00, out_xfer};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result dropped or changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without an outstanding request");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> pending_q >= 3'd2)
		else $error("request side stalled with queue not full");

endmodule

bind chained_hash_table chtab_checker u_chk (.*);
`default_nettype wire
